### hw/rtl/ipd_pkg.sv
// Shared constants, command codes and types for the IR pulse pair decoder.
`timescale 1ns / 1ps

package ipd_pkg;

    // Timing table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int TIME_W   = 16;
    localparam int ENTRY_W  = 2 * TIME_W;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 4;
    localparam int WIDTH_W  = 3;
    localparam int COUNT_W  = 8;
    localparam int CAR_W    = 8;
    localparam int BLEFT_W  = 4;
    localparam int MAX_WIDTH = 4;

    // Stream widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // Command codes carried on the slave-side tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Timing table write port
    typedef struct packed {
        logic                en;
        logic [TBL_AW-1:0]   addr;
        logic [ENTRY_W-1:0]  data;
    } tbl_wr_t;

endpackage

### hw/rtl/ipd_timing_table.sv
// Timing table: on/off durations, one write port and one combinational read port.
`timescale 1ns / 1ps

module ipd_timing_table
    import ipd_pkg::*;
(
    input  logic                clk,
    input  tbl_wr_t             wr,
    input  logic [TBL_AW-1:0]   rd_addr,
    output logic [ENTRY_W-1:0]  rd_data
);

    logic [ENTRY_W-1:0] entry_reg [TABLE_DEPTH];

    // Write one entry per load transaction; contents are undefined until written
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    // Read the entry addressed by the index just gathered
    assign rd_data = entry_reg[rd_addr];

endmodule

### hw/rtl/ir_pulse_pair_decoder_unit.sv
// Top level of the IR pulse pair decoder: input work stage and output register.
`timescale 1ns / 1ps

// Usage:
//   Slave channel s_axis_* carries commands; tuser holds the command code
//   (load table entry, code header, packed index byte), tdata the fields.
//   Master channel m_axis_* carries one on/off pulse pair per transaction;
//   tlast marks the final pair of a code, tuser is the carrier enable.
// Output: a pair appears on the master side in the cycle after the cycle in
//   which its index completes in the work register; an accepted byte passes
//   through the work register and then the output register.
// Flow: load, header and ignored items finish without waiting. A data
//   byte stays in the work register while it yields its pairs (up to eight
//   at one-bit width), each when the output register can take it. The work
//   register takes a new transaction in the cycle the current one finishes,
//   so items follow back to back.
// Reset: clears all control state (carrier 0, width 1, no pairs pending,
//   empty bit buffer); the timing table is undefined until loaded.
// Stall: while the receiver holds m_axis_tready low with a pair waiting,
//   the work stage stops only when it has another pair to emit.
module ir_pulse_pair_decoder_unit
    import ipd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // table_index[3:0], pulse_on_time[19:4], pulse_off_time[35:20],
    // carrier_value[43:36], pair_count[51:44], index_bits[54:52],
    // data_byte[62:55], zero[63]
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_on_time[15:0], out_off_time[31:16], carrier_setting[39:32],
    // pair_number[47:40]
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    // carrier_enable[0]
    output logic                 m_axis_tuser,
    // last_pair
    output logic                 m_axis_tlast
);

    // Work register
    logic                 work_valid_reg, work_valid_next;
    cmd_t                 work_cmd_reg;
    logic [IDX_W-1:0]     work_tidx_reg;
    logic [ENTRY_W-1:0]   work_entry_reg;
    logic [CAR_W-1:0]     work_car_reg;
    logic [COUNT_W-1:0]   work_count_reg;
    logic [WIDTH_W-1:0]   work_ibits_reg;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [BLEFT_W-1:0]   bits_left_reg, bits_left_next;

    // Code state
    logic [CAR_W-1:0]     carrier_reg, carrier_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [COUNT_W-1:0]   remaining_reg, remaining_next;
    logic [COUNT_W-1:0]   sent_reg, sent_next;
    logic [IDX_W-1:0]     partial_reg, partial_next;
    logic [WIDTH_W-1:0]   pcount_reg, pcount_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]    out_on_reg, out_off_reg;
    logic [CAR_W-1:0]     out_car_reg;
    logic [COUNT_W-1:0]   out_num_reg;
    logic                 out_last_reg;

    // Work stage combinational signals
    logic                 s_accept;
    logic                 out_free;
    logic                 work_done;
    logic                 emit;
    logic [WIDTH_W-1:0]   need;
    logic [WIDTH_W-1:0]   take;
    logic [WIDTH_W-1:0]   shift_amt;
    logic [BYTE_W-1:0]    gathered;
    logic [IDX_W-1:0]     index_new;
    logic [WIDTH_W-1:0]   count_new;
    logic                 complete;
    logic [WIDTH_W-1:0]   hdr_width;
    logic                 idx_in_range;
    logic                 load_in_range;
    tbl_wr_t              tbl_wr;
    logic [ENTRY_W-1:0]   tbl_rd_data;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !work_valid_reg || work_done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Gather the next slice of index bits, MSB first
    always_comb
    begin
        need      = width_reg - pcount_reg;
        take      = ({1'b0, need} < bits_left_reg) ? need : bits_left_reg[WIDTH_W-1:0];
        shift_amt = WIDTH_W'(MAX_WIDTH) - take;
        gathered  = {partial_reg, byte_reg[BYTE_W-1 -: IDX_W]} >> shift_amt;
        index_new = gathered[IDX_W-1:0];
        count_new = pcount_reg + take;
        complete  = (count_new >= width_reg);
        idx_in_range  = (32'(index_new) < TABLE_DEPTH);
        load_in_range = (32'(work_tidx_reg) < TABLE_DEPTH);
    end

    // Clamp header width to 1..4
    always_comb
    begin
        if (work_ibits_reg == '0)
        begin
            hdr_width = WIDTH_W'(1);
        end
        else if (work_ibits_reg > WIDTH_W'(MAX_WIDTH))
        begin
            hdr_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            hdr_width = work_ibits_reg;
        end
    end

    // Work stage: update code state and decide when the item is finished
    always_comb
    begin
        carrier_next   = carrier_reg;
        width_next     = width_reg;
        remaining_next = remaining_reg;
        sent_next      = sent_reg;
        partial_next   = partial_reg;
        pcount_next    = pcount_reg;
        byte_next      = byte_reg;
        bits_left_next = bits_left_reg;
        work_done      = 1'b0;
        emit           = 1'b0;
        tbl_wr.en      = 1'b0;
        tbl_wr.addr    = TBL_AW'(work_tidx_reg);
        tbl_wr.data    = work_entry_reg;

        if (work_valid_reg)
        begin
            unique case (work_cmd_reg)
                CMD_LOAD:
                begin
                    tbl_wr.en = load_in_range;
                    work_done = 1'b1;
                end
                CMD_HEADER:
                begin
                    carrier_next   = work_car_reg;
                    remaining_next = work_count_reg;
                    width_next     = hdr_width;
                    sent_next      = '0;
                    partial_next   = '0;
                    pcount_next    = '0;
                    work_done      = 1'b1;
                end
                CMD_DATA:
                begin
                    if (remaining_reg == '0 || bits_left_reg == '0)
                    begin
                        // Code complete or byte used up: drop the rest
                        work_done = 1'b1;
                    end
                    else if (complete)
                    begin
                        // Emit one pair when the output register can take it
                        if (out_free)
                        begin
                            emit           = 1'b1;
                            sent_next      = sent_reg + COUNT_W'(1);
                            remaining_next = remaining_reg - COUNT_W'(1);
                            partial_next   = '0;
                            pcount_next    = '0;
                            byte_next      = byte_reg << take;
                            bits_left_next = bits_left_reg - BLEFT_W'(take);
                            work_done      = (bits_left_next == '0) ||
                                             (remaining_reg == COUNT_W'(1));
                        end
                    end
                    else
                    begin
                        // Byte ends inside an index: keep the partial bits
                        partial_next   = index_new;
                        pcount_next    = count_new;
                        byte_next      = byte_reg << take;
                        bits_left_next = bits_left_reg - BLEFT_W'(take);
                        work_done      = 1'b1;
                    end
                end
                default:
                begin
                    work_done = 1'b1;
                end
            endcase
        end

        // Load a fresh byte on acceptance
        if (s_accept)
        begin
            byte_next      = s_axis_tdata[62:55];
            bits_left_next = BLEFT_W'(BYTE_W);
        end
    end

    always_comb
    begin
        work_valid_next = s_accept ? 1'b1 : (work_valid_reg && !work_done);
        out_valid_next  = emit ? 1'b1 : (out_valid_reg && !m_axis_tready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            carrier_reg    <= '0;
            width_reg      <= WIDTH_W'(1);
            remaining_reg  <= '0;
            sent_reg       <= '0;
            partial_reg    <= '0;
            pcount_reg     <= '0;
            bits_left_reg  <= '0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
            carrier_reg    <= carrier_next;
            width_reg      <= width_next;
            remaining_reg  <= remaining_next;
            sent_reg       <= sent_next;
            partial_reg    <= partial_next;
            pcount_reg     <= pcount_next;
            bits_left_reg  <= bits_left_next;
        end
    end

    // Payload registers: capture the accepted transaction and emitted pair
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (s_accept)
        begin
            work_cmd_reg   <= cmd_t'(s_axis_tuser);
            work_tidx_reg  <= s_axis_tdata[3:0];
            work_entry_reg <= {s_axis_tdata[35:20], s_axis_tdata[19:4]};
            work_car_reg   <= s_axis_tdata[43:36];
            work_count_reg <= s_axis_tdata[51:44];
            work_ibits_reg <= s_axis_tdata[54:52];
        end
        if (emit)
        begin
            out_on_reg   <= idx_in_range ? tbl_rd_data[TIME_W-1:0] : '0;
            out_off_reg  <= idx_in_range ? tbl_rd_data[ENTRY_W-1:TIME_W] : '0;
            out_car_reg  <= carrier_reg;
            out_num_reg  <= sent_reg;
            out_last_reg <= (remaining_reg == COUNT_W'(1));
        end
    end

    ipd_timing_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (TBL_AW'(index_new)),
        .rd_data (tbl_rd_data)
    );

    // Drive the master channel from the output register
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_num_reg, out_car_reg, out_off_reg, out_on_reg};
    assign m_axis_tuser  = (out_car_reg != '0);
    assign m_axis_tlast  = out_last_reg;

endmodule
